[design/smalu_pkg.sv]
// Package: types, constants and helpers shared by the stack machine ALU modules.
package smalu_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_OUT_W = 7;
  localparam int DATA_W      = 32;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [CNT_W-1:0] DEPTH_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] DEPTH_ONE  = CNT_W'(1);

  // Command codes
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_MOD  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
    logic [1:0]               status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_CALC,
    S_DIV,
    S_DIVFIX,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       set_status;
    logic [1:0] status_code;
    logic       do_push;
    logic       ram_rd;
    logic       load_a;
    logic       alu_wr;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic       load_out;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_arith;
    logic is_divmod;
    logic full;
    logic too_short;
    logic zero_top;
    logic div_last;
  } dp_stat_t;

  // Two's complement magnitude, unsigned result
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? ('0 - v) : v;
  endfunction

endpackage

[design/smalu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module smalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/smalu_datapath.sv]
// Datapath: top-of-stack register, depth count, operand store, ALU, divider, output word.
module smalu_datapath
  import smalu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output out_word_t out_word
);

  // The top entry lives in top_r; entries below it live in the RAM.
  logic [2:0]           cmd_r;
  logic [DATA_W-1:0]    pv_r;
  logic [CNT_W-1:0]     depth_r, depth_nxt;
  logic [DATA_W-1:0]    top_r, top_nxt;
  logic [DATA_W-1:0]    a_r;
  logic [1:0]           status_r;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  out_word_t            out_word_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;
  logic [DATA_W-1:0]    alu_res, div_res;
  logic [DATA_W:0]      div_shift, div_diff;

  // status toward the controller
  always_comb begin
    stat.is_push   = (cmd_r == CMD_PUSH);
    stat.is_arith  = cmd_r inside {[CMD_ADD:CMD_MOD]};
    stat.is_divmod = cmd_r inside {CMD_DIV, CMD_MOD};
    stat.full      = (depth_r == DEPTH_FULL);
    stat.too_short = (depth_r < DEPTH_TWO);
    stat.zero_top  = (top_r == '0);
    stat.div_last  = (cnt_r == '1);
  end

  // operand store: old top spills below on push, second entry read for ops
  assign ram_we    = cmd.do_push && (depth_r != '0);
  assign ram_waddr = ADDR_W'(depth_r - DEPTH_ONE);
  assign ram_raddr = ADDR_W'(depth_r - DEPTH_TWO);

  smalu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .re    (cmd.ram_rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // add / sub / mul, left operand is the second entry
  always_comb begin
    case (cmd_r)
      CMD_ADD: alu_res = a_r + top_r;
      CMD_SUB: alu_res = a_r - top_r;
      CMD_MUL: alu_res = a_r * top_r;
      default: alu_res = '0;
    endcase
  end

  // one restoring division step per cycle on magnitudes
  always_comb begin
    div_shift = {rem_r, quo_r[DATA_W-1]};
    div_diff  = div_shift - {1'b0, dvs_r};
    if (!div_diff[DATA_W]) begin
      rem_nxt = div_diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = div_shift[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  // sign fix: quotient truncates toward zero, remainder follows the dividend
  always_comb begin
    if (cmd_r == CMD_MOD) begin
      div_res = a_r[DATA_W-1] ? ('0 - rem_r) : rem_r;
    end else begin
      div_res = (a_r[DATA_W-1] ^ top_r[DATA_W-1]) ? ('0 - quo_r) : quo_r;
    end
  end

  // next top and depth
  always_comb begin
    top_nxt   = top_r;
    depth_nxt = depth_r;
    if (cmd.do_push) begin
      top_nxt   = pv_r;
      depth_nxt = depth_r + DEPTH_ONE;
    end else if (cmd.alu_wr) begin
      top_nxt   = alu_res;
      depth_nxt = depth_r - DEPTH_ONE;
    end else if (cmd.div_wr) begin
      top_nxt   = div_res;
      depth_nxt = depth_r - DEPTH_ONE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      cnt_r   <= '0;
    end else begin
      depth_r <= depth_nxt;
      if (cmd.div_init) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.latch_in) begin
      cmd_r <= in_word.cmd;
      pv_r  <= in_word.push_value;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.load_a) begin
      a_r <= ram_rdata;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= mag(a_r);
      dvs_r <= mag(top_r);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.load_out) begin
      out_word_r.top_value   <= (depth_r != '0) ? top_r : '0;
      out_word_r.stack_depth <= DEPTH_OUT_W'(depth_r);
      out_word_r.status      <= status_r;
    end
  end

  assign out_word = out_word_r;

  // depth never passes the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_FULL)
    else $error("stack depth above capacity");

  // a push grows the stack by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push |=> depth_r == $past(depth_r) + DEPTH_ONE)
    else $error("push did not grow stack by one");

  // an operation result replaces two entries with one
  a_op_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alu_wr || cmd.div_wr) |=> depth_r == $past(depth_r) - DEPTH_ONE)
    else $error("operation did not shrink stack by one");

endmodule

[design/smalu_ctrl.sv]
// Controller: sequences decode, operand fetch, ALU or divider, and output hand-off.
module smalu_ctrl
  import smalu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   op_go;
  logic   err_any;

  assign out_free = !out_valid_r || !out_stall;
  assign err_any  = (stat.is_push && stat.full) ||
                    (stat.is_arith && (stat.too_short || (stat.is_divmod && stat.zero_top)));
  assign op_go    = stat.is_arith && !err_any;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_DECODE;
      S_DECODE:    state_nxt = op_go ? S_READ_WAIT : S_FINISH;
      S_READ_WAIT: state_nxt = S_CALC;
      S_CALC:      state_nxt = stat.is_divmod ? S_DIV : S_FINISH;
      S_DIV:       if (stat.div_last) state_nxt = S_DIVFIX;
      S_DIVFIX:    state_nxt = S_FINISH;
      S_FINISH:    if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        if (stat.is_push && stat.full) begin
          cmd.status_code = ST_FULL;
        end else if (stat.is_arith && stat.too_short) begin
          cmd.status_code = ST_SHORT;
        end else if (stat.is_arith && stat.is_divmod && stat.zero_top) begin
          cmd.status_code = ST_DIVZERO;
        end else begin
          cmd.status_code = ST_OK;
        end
        cmd.do_push = stat.is_push && !stat.full;
        cmd.ram_rd  = op_go;
      end
      S_READ_WAIT: cmd.load_a = 1'b1;
      S_CALC: begin
        cmd.div_init = stat.is_divmod;
        cmd.alu_wr   = !stat.is_divmod;
      end
      S_DIV:    cmd.div_step = 1'b1;
      S_DIVFIX: cmd.div_wr   = 1'b1;
      S_FINISH: cmd.load_out = out_free;
      default: ;
    endcase
  end

  // output word valid
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted word always moves on to decode
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_DECODE)
    else $error("accepted word not decoded");

  // last divider step leads to the sign fix
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && stat.div_last) |=> state_r == S_DIVFIX)
    else $error("divider did not finish");

  // a finished word waits while the output slot is held
  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && out_stall) |=> state_r == S_FINISH && out_valid_r)
    else $error("result overwrote a stalled output word");

endmodule

[design/stack_machine_alu_core.sv]
// Stack machine ALU top level: operand stack of signed 32-bit words with arithmetic commands.
//
// Input channel (in_valid / in_stall / in_word): one command word per handshake,
// push or add/sub/mul/div/mod. A word is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall / out_word): exactly one result word per
// command, carrying the new top of stack (zero when empty), depth and status.
// Commands run one at a time. After decode each command takes its own states before
// the finish state, which loads the result into the output register once it is free:
//   push, errors, unused codes: none
//   add, sub, mul: read wait, calc
//   div, mod: read wait, calc, 32-step restoring divider (one quotient bit a cycle),
//   sign fix
// The next word can be accepted in the cycle after the result is loaded into the output
// register, and a finished result can wait there while a new command starts.
// If the receiver holds out_stall, the word stays unchanged; a following command
// completes its work and then waits in its final state until the output frees.
// Reset (rst_n low, synchronous) empties the stack and drops any pending output.
// Stack entry values need no clearing: only entries below the depth are read.
module stack_machine_alu_core
  import smalu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // sequencing
  smalu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (ctl_cmd)
  );

  // stack, ALU and divider
  smalu_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (ctl_cmd),
    .stat     (dp_stat),
    .out_word (out_word)
  );

endmodule
